// ===== rtl/fhdp_pkg.sv =====
// Shared types, constants and arithmetic helpers for the fire heat diffusion palette block.
package fhdp_pkg;

  localparam int GRID_WIDTH_DEF  = 16;
  localparam int GRID_HEIGHT_DEF = 20;
  localparam int HEAT_BITS_DEF   = 16;

  localparam int IDX_BITS = 8;
  localparam int CFG_BITS = 16;
  localparam int COL_BITS = 8;
  localparam int FLAME_BITS = 17;
  localparam int FLAME_BASE_BITS = 24;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;
  localparam logic [15:0] SEED_RST  = 16'd44257;
  localparam logic [FLAME_BITS-1:0] FLAME_ONE  = 17'd65536;
  localparam logic [FLAME_BITS-1:0] FLAME_HALF = 17'd32768;

  localparam logic MODE_ADVANCE = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  localparam logic REG_ANAGLYPH = 1'b0;
  localparam logic REG_SEED     = 1'b1;

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_SCAN    = 17'b00000000000000010,
    S_DRAIN   = 17'b00000000000000100,
    S_DRAW    = 17'b00000000000001000,
    S_SQ      = 17'b00000000000010000,
    S_CUBE    = 17'b00000000000100000,
    S_SEED_WR = 17'b00000000001000000,
    S_FLIP    = 17'b00000000010000000,
    S_MOD     = 17'b00000000100000000,
    S_REM     = 17'b00000001000000000,
    S_FETCH   = 17'b00000010000000000,
    S_FLAME   = 17'b00000100000000000,
    S_SQF     = 17'b00001000000000000,
    S_POW     = 17'b00010000000000000,
    S_COLOR   = 17'b00100000000000000,
    S_MIX     = 17'b01000000000000000,
    S_OUT     = 17'b10000000000000000
  } fhdp_state_t;

  typedef struct packed {
    logic       ana_load;
    logic       seed_load;
    logic       idx_load;
    logic       fetch;
    logic       fetch_zero;
    logic       draw;
    logic [1:0] draw_sel;
    logic       seed_sq;
    logic       seed_cube;
    logic       seed_wr;
    logic       flip;
    logic       mod;
    logic       rem;
    logic       pix_rd;
    logic       flame;
    logic       square;
    logic       pow;
    logic       color;
    logic       mix;
    logic       out_load;
  } fhdp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } fhdp_status_t;

  // Galois shift, taps 0xB400
  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  // floor(x / 10) by reciprocal, exact for any 24-bit x
  function automatic logic [23:0] div10(input logic [23:0] x);
    logic [51:0] p;
    p = 52'(x) * 52'(26843546);
    return p[28 +: 24];
  endfunction

  // floor(x / 100) by reciprocal, exact for the mix sums
  function automatic logic [7:0] div100(input logic [14:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'(41944);
    return p[29:22];
  endfunction

endpackage

// ===== rtl/fhdp_ctrl.sv =====
// Sequencer for frame advance, bottom-row seeding and pixel readout.
module fhdp_ctrl import fhdp_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  localparam int RW  = $clog2(GRID_HEIGHT),
  localparam int CXW = $clog2(GRID_WIDTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           mode,
  output logic           out_valid,
  input  logic           out_stall,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  fhdp_status_t   status,
  output fhdp_cmd_t      cmd,
  output logic [RW-1:0]  row,
  output logic [CXW-1:0] col
);

  fhdp_state_t state, state_next;
  logic [RW-1:0]  row_next;
  logic [CXW-1:0] col_next;
  logic [1:0]     dcnt, dcnt_next;
  logic [3:0]     pcnt, pcnt_next;
  logic           out_valid_next;
  logic           accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    row_next       = row;
    col_next       = col;
    dcnt_next      = dcnt;
    pcnt_next      = pcnt;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.ana_load   = cfg_we && (cfg_index == REG_ANAGLYPH);
    cmd.seed_load  = cfg_we && (cfg_index == REG_SEED);
    cmd.draw_sel   = dcnt;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (mode == MODE_ADVANCE) begin
            row_next   = '0;
            col_next   = '0;
            state_next = S_SCAN;
          end else begin
            cmd.idx_load = 1'b1;
            state_next   = S_MOD;
          end
        end
      end
      S_SCAN: begin
        cmd.fetch      = 1'b1;
        cmd.fetch_zero = (col == CXW'(GRID_WIDTH));
        if (col == CXW'(GRID_WIDTH)) begin
          col_next = '0;
          if (row == RW'(GRID_HEIGHT - 2)) begin
            state_next = S_DRAIN;
          end else begin
            row_next = row + 1'b1;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          dcnt_next  = '0;
          state_next = S_DRAW;
        end
      end
      S_DRAW: begin
        cmd.draw = 1'b1;
        if (dcnt == 2'd2) begin
          state_next = S_SQ;
        end else begin
          dcnt_next = dcnt + 1'b1;
        end
      end
      S_SQ: begin
        cmd.seed_sq = 1'b1;
        state_next  = S_CUBE;
      end
      S_CUBE: begin
        cmd.seed_cube = 1'b1;
        state_next    = S_SEED_WR;
      end
      S_SEED_WR: begin
        cmd.seed_wr = 1'b1;
        dcnt_next   = '0;
        if (col == CXW'(GRID_WIDTH - 1)) begin
          state_next = S_FLIP;
        end else begin
          col_next   = col + 1'b1;
          state_next = S_DRAW;
        end
      end
      S_FLIP: begin
        cmd.flip   = 1'b1;
        state_next = S_IDLE;
      end
      S_MOD: begin
        cmd.mod    = 1'b1;
        state_next = S_REM;
      end
      S_REM: begin
        cmd.rem    = 1'b1;
        state_next = S_FETCH;
      end
      S_FETCH: begin
        cmd.pix_rd = 1'b1;
        state_next = S_FLAME;
      end
      S_FLAME: begin
        cmd.flame  = 1'b1;
        state_next = S_SQF;
      end
      S_SQF: begin
        cmd.square = 1'b1;
        pcnt_next  = '0;
        state_next = S_POW;
      end
      S_POW: begin
        cmd.pow = 1'b1;
        if (pcnt == 4'd8) begin
          state_next = S_COLOR;
        end else begin
          pcnt_next = pcnt + 1'b1;
        end
      end
      S_COLOR: begin
        cmd.color  = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free or its beat leaves now
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      col       <= '0;
      dcnt      <= '0;
      pcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      row       <= row_next;
      col       <= col_next;
      dcnt      <= dcnt_next;
      pcnt      <= pcnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/fhdp_datapath.sv =====
// Heat memory, diffusion pipeline, seeding arithmetic and palette mapping.
module fhdp_datapath import fhdp_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int HEAT_BITS   = HEAT_BITS_DEF,
  localparam int RW  = $clog2(GRID_HEIGHT),
  localparam int CXW = $clog2(GRID_WIDTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  fhdp_cmd_t           cmd,
  input  logic [RW-1:0]       row,
  input  logic [CXW-1:0]      col,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic [IDX_BITS-1:0] pixel_index,
  output fhdp_status_t        status,
  output logic [COL_BITS-1:0] red,
  output logic [COL_BITS-1:0] green,
  output logic [COL_BITS-1:0] blue,
  output logic [COL_BITS-1:0] alpha
);

  localparam int HB    = HEAT_BITS;
  localparam int FRAC  = HB - 3;
  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(2 * CELLS);
  localparam int CW    = $clog2(CELLS);
  localparam int TW    = HB + 5;
  localparam int SB    = HB + 10;
  localparam int K6    = SB + 10;
  localparam int PW    = 2 * SB + 1;
  localparam longint M636 = ((64'd1 << K6) + 64'd635) / 64'd636;
  localparam int KI    = 21;
  localparam longint MI = ((64'd1 << KI) + longint'(CELLS) - 64'd1) / longint'(CELLS);
  localparam logic [HB-1:0] SEED_C = HB'((2 * (1 << FRAC)) / 10);

  // heat memory: both buffers, cur at front*CELLS
  logic [HB-1:0] mem [2*CELLS];
  logic [HB-1:0] q0, q1;
  logic          rz;
  logic          front;
  logic [1:0]    buf_valid;
  logic          ana;
  logic [15:0]   lfsr;

  logic [AW-1:0] cur_base, nxt_base, ra0, ra1, wa;
  logic [HB-1:0] wd;
  logic          we;
  logic [CXW-1:0] colx;

  assign cur_base = front ? AW'(CELLS) : '0;
  assign nxt_base = front ? '0 : AW'(CELLS);

  // pixel index wrap
  logic [IDX_BITS-1:0] idx, qidx;
  logic [CW-1:0]       rem;
  logic [29:0]         mi_prod;
  logic [15:0]         rem_w;

  assign mi_prod = 30'(idx) * 30'(MI);
  assign rem_w   = 16'(idx) - 16'(qidx) * 16'(CELLS);

  assign colx = cmd.fetch_zero ? '0 : col;
  assign ra0  = cmd.pix_rd ? AW'(cur_base + AW'(rem))
                           : AW'(cur_base + AW'(row) * AW'(GRID_WIDTH) + AW'(colx));
  assign ra1  = AW'(cur_base + (AW'(row) + 1'b1) * AW'(GRID_WIDTH) + AW'(colx));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q0 <= mem[ra0];
    q1 <= mem[ra1];
    rz <= !buf_valid[front];
  end

  // diffusion pipeline
  logic           sh_v, sh_zero, win_v, s_v, p_v;
  logic [CXW-1:0] sh_col, win_col, s_col, p_col;
  logic [RW-1:0]  sh_row, win_row, s_row, p_row;
  logic [HB-1:0]  t0, t1, t2, b0, b1, b2, d0, d1;
  logic [TW-1:0]  tot;
  logic [SB-1:0]  s;
  logic [PW-1:0]  prod;

  assign d0  = (sh_zero || rz) ? '0 : q0;
  assign d1  = (sh_zero || rz) ? '0 : q1;
  assign tot = TW'(b1) * TW'(19) + TW'(b0) + TW'(b2) + TW'(t0) + TW'(t1) + TW'(t2);
  assign status.pipe_busy = sh_v || win_v || s_v || p_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_v  <= 1'b0;
      win_v <= 1'b0;
      s_v   <= 1'b0;
      p_v   <= 1'b0;
    end else begin
      sh_v  <= cmd.fetch;
      win_v <= sh_v && (sh_col != '0);
      s_v   <= win_v;
      p_v   <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    sh_zero <= cmd.fetch_zero;
    sh_col  <= col;
    sh_row  <= row;
    if (sh_v) begin
      // column zero enters with nothing to its left
      t2 <= d0;
      t1 <= (sh_col == '0) ? '0 : t2;
      t0 <= t1;
      b2 <= d1;
      b1 <= (sh_col == '0) ? '0 : b2;
      b0 <= b1;
    end
    win_col <= sh_col - 1'b1;
    win_row <= sh_row;
    s       <= SB'(tot) * SB'(25);
    s_col   <= win_col;
    s_row   <= win_row;
    prod    <= PW'(s) * PW'(M636);
    p_col   <= s_col;
    p_row   <= s_row;
  end

  // bottom-row seeding
  logic [15:0]        r [3];
  logic [31:0]        sq;
  logic [47:0]        p48;
  logic [HB-1:0]      sa, sbv;
  logic [16+FRAC-1:0] r2s;
  logic [FRAC-1:0]    r2d;

  assign p48 = 48'(sq) * 48'(r[1]);
  assign r2s = {r[2], {FRAC{1'b0}}};
  assign r2d = FRAC'(r2s >> 16);

  always_ff @(posedge clk) begin
    if (cmd.draw) begin
      r[cmd.draw_sel] <= lfsr_step(lfsr);
    end
    if (cmd.seed_sq) begin
      sq <= 32'(r[0]) * 32'(r[0]);
    end
    if (cmd.seed_cube) begin
      sa  <= HB'(p48 >> (46 - FRAC));
      sbv <= HB'(div10(24'(r2d)));
    end
  end

  // write port
  always_comb begin
    if (cmd.seed_wr) begin
      we = 1'b1;
      wa = AW'(nxt_base + AW'(GRID_HEIGHT - 1) * AW'(GRID_WIDTH) + AW'(col));
      wd = HB'(sa + sbv + SEED_C);
    end else begin
      we = p_v;
      wa = AW'(nxt_base + AW'(p_row) * AW'(GRID_WIDTH) + AW'(p_col));
      wd = prod[K6 +: HB];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= 1'b0;
      buf_valid <= 2'b00;
      ana       <= 1'b0;
      lfsr      <= SEED_RST;
    end else begin
      if (cmd.flip) begin
        buf_valid[~front] <= 1'b1;
        front             <= ~front;
      end
      if (cmd.ana_load) begin
        ana <= cfg_data[0];
      end
      if (cmd.seed_load) begin
        lfsr <= cfg_data;
      end else if (cmd.draw) begin
        lfsr <= lfsr_step(lfsr);
      end
    end
  end

  // palette
  logic [FLAME_BITS-1:0]      f, p;
  logic [2*FLAME_BITS-1:0]    fsq;
  logic [HB+4:0]              hx;
  logic [HB+20:0]             hw;
  logic [FLAME_BASE_BITS-1:0] fq;
  logic [2*FLAME_BITS-1:0]    pp;
  logic [24:0]                rf;
  logic [41:0]                gf;
  logic [24:0]                bf;
  logic [COL_BITS-1:0]        cr, cg, cb, ca;
  logic [14:0]                sr, sg, sbs;

  assign hx = (HB+5)'(q0) * (HB+5)'(18);
  assign hw = {hx, 16'b0} >> FRAC;
  assign fq = div10(FLAME_BASE_BITS'(hw));
  assign pp = (2*FLAME_BITS)'(p) * (2*FLAME_BITS)'(f);
  assign rf = 25'(f) * 25'(155);
  assign gf = {fsq, 8'b0} - 42'(fsq);
  assign bf = {p, 8'b0} - 25'(p);

  always_ff @(posedge clk) begin
    if (cmd.idx_load) begin
      idx <= pixel_index;
    end
    if (cmd.mod) begin
      qidx <= mi_prod[KI +: IDX_BITS];
    end
    if (cmd.rem) begin
      rem <= CW'(rem_w);
    end
    if (cmd.flame) begin
      if (rz) begin
        f <= '0;
      end else if (fq > FLAME_BASE_BITS'(FLAME_ONE)) begin
        f <= FLAME_ONE;
      end else begin
        f <= FLAME_BITS'(fq);
      end
    end
    if (cmd.square) begin
      fsq <= (2*FLAME_BITS)'(f) * (2*FLAME_BITS)'(f);
      p   <= f;
    end else if (cmd.pow) begin
      p <= FLAME_BITS'(pp >> 16);
    end
    if (cmd.color) begin
      cr <= COL_BITS'(8'd100 + COL_BITS'(rf >> 16));
      cg <= COL_BITS'(gf >> 32);
      cb <= COL_BITS'(bf >> 16);
      ca <= (f < FLAME_HALF) ? 8'd0 : 8'd255;
    end
    if (cmd.mix) begin
      sr  <= 15'(cr) * 15'(30) + 15'(cg) * 15'(59) + 15'(cb) * 15'(11);
      sg  <= 15'(cr) * 15'(30) + 15'(cg) * 15'(70);
      sbs <= 15'(cr) * 15'(30) + 15'(cb) * 15'(70);
    end
    if (cmd.out_load) begin
      red   <= ana ? div100(sr) : cr;
      green <= ana ? div100(sg) : cg;
      blue  <= ana ? div100(sbs) : cb;
      alpha <= ca;
    end
  end

endmodule

// ===== rtl/fire_heat_diffusion_palette_core.sv =====
// Top level of the fire heat diffusion palette block.
// An advance item (mode 0) rebuilds the whole grid: each of the GRID_HEIGHT-1 upper rows
// streams through the diffusion pipeline (two memory read ports feed a sliding 3x2
// window), then the pipeline drains, then each bottom-row cell takes three LFSR draws
// and the seed arithmetic, and last the two heat buffers swap.
// A read item (mode 1) runs the nine-step flame power iteration on one shared multiplier.
// One item is in work at a time; a finished pixel waits in the output register while
// the next item is taken. Both heat buffers read as zero until their first full frame
// is written, so no clearing pass follows reset.
module fire_heat_diffusion_palette_core import fhdp_pkg::*; #(
  parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
  parameter int HEAT_BITS   = HEAT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                mode,
  input  logic [IDX_BITS-1:0] pixel_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COL_BITS-1:0] red,
  output logic [COL_BITS-1:0] green,
  output logic [COL_BITS-1:0] blue,
  output logic [COL_BITS-1:0] alpha,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  localparam int RW  = $clog2(GRID_HEIGHT);
  localparam int CXW = $clog2(GRID_WIDTH + 1);

  fhdp_cmd_t      cmd;
  fhdp_status_t   status;
  logic [RW-1:0]  row;
  logic [CXW-1:0] col;

  fhdp_ctrl #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .status   (status),
    .cmd      (cmd),
    .row      (row),
    .col      (col)
  );

  fhdp_datapath #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT),
    .HEAT_BITS  (HEAT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .row        (row),
    .col        (col),
    .cfg_data   (cfg_data),
    .pixel_index(pixel_index),
    .status     (status),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .alpha      (alpha)
  );

endmodule

// ===== rtl/fhdp_checker.sv =====
// Port-level checks for the fire heat diffusion palette block, bound to the top level.
module fhdp_checker import fhdp_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                mode,
  input logic                out_valid,
  input logic                out_stall,
  input logic [COL_BITS-1:0] alpha
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the item finished");

  a_advance_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_ADVANCE && !out_valid |=> !out_valid)
    else $error("advance produced a result");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  a_alpha_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (alpha == 8'd0 || alpha == 8'd255))
    else $error("alpha outside its two values");

endmodule

bind fire_heat_diffusion_palette_core fhdp_checker u_fhdp_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .mode     (mode),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .alpha    (alpha)
);

// ===== sim/fire_heat_diffusion_palette_core_test.sv =====
// Self-checking testbench for the fire heat diffusion palette core.
module fire_heat_diffusion_palette_core_test;
  import fhdp_pkg::*;

  localparam int WIDTH = 16;
  localparam int HEIGHT = 20;
  localparam int CELLS = WIDTH * HEIGHT;
  localparam int FRAME_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic mode = MODE_ADVANCE;
  logic [IDX_BITS-1:0] pixel_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COL_BITS-1:0] red, green, blue, alpha;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_ANAGLYPH;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // local copy of grid and settings
  logic [15:0] heat [2][CELLS];
  logic front_sel;
  logic [15:0] lfsr;
  logic anaglyph;

  pixel_t pending_pixels [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int errors = 0;
  longint cycles = 0;

  fire_heat_diffusion_palette_core dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** fire_heat_diffusion_palette_core: FAILED **");
      $finish;
    end
  end

  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    logic [15:0] s;
    s = v >> 1;
    if (v[0]) s = s ^ 16'hB400;
    return s;
  endfunction

  function automatic logic [15:0] seed_heat();
    longint unsigned r0, r1, r2, a, b;
    lfsr = lfsr_next(lfsr); r0 = lfsr;
    lfsr = lfsr_next(lfsr); r1 = lfsr;
    lfsr = lfsr_next(lfsr); r2 = lfsr;
    a = (r0 * r0 * r1) >> 33;
    b = (r2 << 13) / 655360;
    return 16'(a + b + 1638);
  endfunction

  function automatic void advance_frame();
    int src, dst, below;
    longint unsigned total;
    src = front_sel;
    dst = !front_sel;
    for (int y = 0; y < HEIGHT; y++) begin
      for (int x = 0; x < WIDTH; x++) begin
        if (y == HEIGHT - 1) begin
          heat[dst][x + y * WIDTH] = seed_heat();
        end else begin
          below = (y + 1) % HEIGHT;
          total = 18 * longint'(heat[src][x + below * WIDTH]);
          for (int sx = x - 1; sx <= x + 1; sx++)
            for (int sy = y; sy <= y + 1; sy++)
              if (sx >= 0 && sx < WIDTH) total += heat[src][sx + sy * WIDTH];
          heat[dst][x + y * WIDTH] = 16'(total * 25 / 636);
        end
      end
    end
    front_sel = !front_sel;
  endfunction

  function automatic pixel_t pixel_color(input int idx);
    longint unsigned h, f, p, rr, gg, bb, aa, mr, mg, mb;
    pixel_t px;
    h = heat[front_sel][idx % CELLS];
    f = ((h * 18) << 16) / 81920;
    if (f > 65536) f = 65536;
    rr = 100 + ((f * 155) >> 16);
    gg = (f * f * 255) >> 32;
    p = f;
    for (int i = 0; i < 9; i++) p = (p * f) >> 16;
    bb = (p * 255) >> 16;
    aa = (f < 32768) ? 0 : 255;
    if (anaglyph) begin
      mr = (rr * 30 + gg * 59 + bb * 11) / 100;
      mg = (rr * 30 + gg * 70) / 100;
      mb = (rr * 30 + bb * 70) / 100;
      rr = mr; gg = mg; bb = mb;
    end
    px.r = 8'(rr); px.g = 8'(gg); px.b = 8'(bb); px.a = 8'(aa);
    return px;
  endfunction

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall = 1'b1;
      hold_off = hold_off - 1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel beat r=%0d g=%0d b=%0d a=%0d", red, green, blue, alpha);
        errors++;
      end else begin
        want = pending_pixels.pop_front();
        if (red !== want.r) begin
          $error("red: expected %0d, got %0d", want.r, red); errors++;
        end
        if (green !== want.g) begin
          $error("green: expected %0d, got %0d", want.g, green); errors++;
        end
        if (blue !== want.b) begin
          $error("blue: expected %0d, got %0d", want.b, blue); errors++;
        end
        if (alpha !== want.a) begin
          $error("alpha: expected %0d, got %0d", want.a, alpha); errors++;
        end
      end
    end
  end

  task automatic send_item(input logic m, input logic [7:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    mode = m;
    pixel_index = idx;
    do @(posedge clk); while (in_stall);
    if (m == MODE_ADVANCE) advance_frame();
    else pending_pixels.push_back(pixel_color(idx));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (FRAME_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    if (idx == REG_ANAGLYPH) anaglyph = data[0];
    else lfsr = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_item(input int advance_pct);
    if ($urandom_range(99) < advance_pct) send_item(MODE_ADVANCE, 8'($urandom));
    else send_item(MODE_READ, 8'($urandom_range(255)));
  endtask

  task automatic test_cold_grid();
    send_item(MODE_READ, 8'd0);
    send_item(MODE_READ, 8'd255);
    send_item(MODE_ADVANCE, 8'hFF);
    send_item(MODE_READ, 8'd240);
    settle();
  endtask

  task automatic test_zero_seed();
    write_reg(REG_SEED, 16'd0);
    repeat (3) send_item(MODE_ADVANCE, 8'd0);
    send_item(MODE_READ, 8'd255);
    send_item(MODE_READ, 8'd128);
    settle();
  endtask

  task automatic test_extremes();
    write_reg(REG_SEED, 16'hFFFF);
    write_reg(REG_ANAGLYPH, 16'd1);
    for (int i = 0; i < 8; i++) send_item(MODE_ADVANCE, 8'h00);
    send_item(MODE_READ, 8'd0);
    send_item(MODE_READ, 8'd15);
    send_item(MODE_READ, 8'd240);
    send_item(MODE_READ, 8'd255);
    send_item(MODE_READ, 8'd170);
    send_item(MODE_READ, 8'd85);
    settle();
    write_reg(REG_SEED, 16'd1);
  endtask

  task automatic test_random_phase(input int n, input int s_idle, input int r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int i = 0; i < n; i++) random_item(25);
    settle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 400;
    for (int i = 0; i < 12; i++) send_item(MODE_READ, 8'($urandom));
    settle();
  endtask

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      heat[0][i] = '0;
      heat[1][i] = '0;
    end
    front_sel = 1'b0;
    lfsr = SEED_RST;
    anaglyph = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_cold_grid();
    test_zero_seed();
    test_extremes();
    write_reg(REG_ANAGLYPH, 16'd0);
    test_random_phase(230, 10, 87);
    write_reg(REG_ANAGLYPH, 16'd1);
    write_reg(REG_SEED, 16'($urandom_range(65535, 1)));
    test_random_phase(230, 87, 10);
    write_reg(REG_ANAGLYPH, 16'd0);
    write_reg(REG_SEED, 16'hFFFF);
    test_random_phase(230, 0, 0);
    test_backpressure();

    if (errors == 0)
      $display("** fire_heat_diffusion_palette_core: PASSED **");
    else
      $display("** fire_heat_diffusion_palette_core: FAILED **");
    $finish;
  end

endmodule
